// ----- src/ppma_pkg.sv -----
// ----------------------------------------------------------------------------
// ppma_pkg
// Shared types and codes for the prime power modular arithmetic unit.
// ----------------------------------------------------------------------------
package ppma_pkg;

  // Action codes of an input item.
  localparam logic [2:0] ACT_ADD = 3'd0;
  localparam logic [2:0] ACT_SUB = 3'd1;
  localparam logic [2:0] ACT_MUL = 3'd2;
  localparam logic [2:0] ACT_DIV = 3'd3;
  localparam logic [2:0] ACT_NEG = 3'd4;
  localparam logic [2:0] ACT_INV = 3'd5;
  localparam logic [2:0] ACT_POW = 3'd6;
  localparam logic [2:0] ACT_RED = 3'd7;

  // Error codes of a result.
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_INV  = 2'd1;
  localparam logic [1:0] ERR_DIV  = 2'd2;
  localparam logic [1:0] ERR_MOD  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_PRIME = 2'd0;
  localparam logic [1:0] REG_EXP   = 2'd1;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MADD,
    OP_MSUB
  } arith_op_t;

  typedef enum logic [5:0] {
    S_IDLE, S_MI, S_MP0, S_MP, S_MPC, S_CHK, S_DV, S_RA, S_RB, S_DISP,
    S_ML, S_MULD, S_SP0, S_SP1, S_SP2, S_DVA, S_DVB, S_DVC, S_DVD, S_DVE,
    S_IV1, S_IV2, S_IV3, S_IVA, S_IVB, S_PW, S_PW2, S_PW3, S_PW4,
    S_FIN, S_FIN2, S_OUT
  } state_t;

endpackage

// ----- src/ppma_arith.sv -----
// ----------------------------------------------------------------------------
// ppma_arith
// Shared adder, subtractor and modular add/subtract unit.
// ----------------------------------------------------------------------------
module ppma_arith import ppma_pkg::*; #(
  parameter int UW = 50
) (
  input  arith_op_t         op,
  input  logic [UW-1:0]     x,
  input  logic [UW-1:0]     y,
  input  logic [UW-1:0]     m,
  output logic [UW-1:0]     res,
  output logic              ge
);

  logic [UW-1:0] sum;
  logic [UW-1:0] diff;
  logic [UW-1:0] sum_red;

  assign sum     = x + y;
  assign diff    = x - y;
  assign sum_red = sum - m;

  always_comb begin
    ge  = (x >= y);
    res = diff;
    case (op)
      OP_ADD:  res = sum;
      OP_SUB:  res = diff;
      OP_MADD: res = (sum >= m) ? sum_red : sum;
      // A negative difference wraps, so adding the modulus restores it.
      OP_MSUB: res = (x >= y) ? diff : diff + m;
      default: res = diff;
    endcase
  end

endmodule

// ----- src/ppma_seq.sv -----
// ----------------------------------------------------------------------------
// ppma_seq
// Sequencer and working registers; the add, subtract, multiply and division steps go through the shared unit.
// ----------------------------------------------------------------------------
module ppma_seq import ppma_pkg::*; #(
  parameter int RESIDUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic [31:0]        in_operand_a,
  input  logic [31:0]        in_operand_b,
  input  logic [15:0]        prime,
  input  logic [5:0]         expo,
  input  logic               cfg_wr,
  output logic               out_valid,
  output logic [31:0]        out_residue,
  output logic [5:0]         out_valuation,
  output logic [31:0]        out_unit_part,
  output logic [1:0]         out_error_code
);

  localparam int MW = RESIDUE_WIDTH + 1;
  localparam int NW = (MW > 32) ? MW : 32;
  localparam int UW = RESIDUE_WIDTH + 18;
  localparam int CW = $clog2(NW + 1);
  localparam logic [UW-1:0] LIM =
    (UW'(1) << RESIDUE_WIDTH) - UW'((RESIDUE_WIDTH >= 64) ? 1 : 0);

  function automatic logic [31:0] mag32(input logic [31:0] x);
    logic [31:0] t;
    t = ~x + 32'd1;
    return x[31] ? t : x;
  endfunction

  state_t state_r, state_nxt;
  state_t ret_r, ret_nxt, sret_r, sret_nxt, iret_r, iret_nxt;

  logic            modok_r, modok_nxt, moderr_r, moderr_nxt;
  logic [MW-1:0]   mod_r, mod_nxt;
  logic [5:0]      i_r, i_nxt;
  logic [UW-1:0]   pacc_r, pacc_nxt;
  logic [3:0]      pcnt_r, pcnt_nxt;

  logic [2:0]      act_r, act_nxt;
  logic [31:0]     opa_r, opa_nxt, opb_r, opb_nxt, e_r, e_nxt;
  logic [MW-1:0]   a_r, a_nxt, b_r, b_nxt, r_r, r_nxt, base_r, base_nxt;
  logic [MW-1:0]   ua_r, ua_nxt;
  logic [5:0]      va_r, va_nxt, k_r, k_nxt, sv_r, sv_nxt;
  logic [MW-1:0]   su_r, su_nxt;

  logic [NW-1:0]   dn_r, dn_nxt;
  logic [MW-1:0]   dd_r, dd_nxt, rem_r, rem_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  logic [MW-1:0]   mx_r, mx_nxt, my_r, my_nxt, acc_r, acc_nxt;
  logic            mph_r, mph_nxt;

  logic [MW-1:0]   r0_r, r0_nxt, r1_r, r1_nxt, t0_r, t0_nxt, t1_r, t1_nxt;
  logic            invok_r, invok_nxt;

  logic            ov_r, ov_nxt;
  logic [31:0]     ores_r, ores_nxt, ounit_r, ounit_nxt;
  logic [5:0]      oval_r, oval_nxt;
  logic [1:0]      oerr_r, oerr_nxt;

  arith_op_t       uop;
  logic [UW-1:0]   ux, uy, ures;
  logic            uge;
  logic [MW:0]     rem_t;
  logic [MW-1:0]   pmod;

  assign rem_t = {rem_r, dn_r[NW-1]};
  assign pmod  = (expo == 6'd1) ? '0 : MW'(prime);

  ppma_arith #(.UW(UW)) u_arith (
    .op  (uop),
    .x   (ux),
    .y   (uy),
    .m   (UW'(mod_r)),
    .res (ures),
    .ge  (uge)
  );

  // Operand selection for the shared unit.
  always_comb begin
    uop = OP_SUB;
    ux  = '0;
    uy  = '0;
    case (state_r) inside
      S_MP: begin
        uop = OP_ADD;
        ux  = pacc_r << 1;
        uy  = prime[pcnt_r] ? UW'(mod_r) : '0;
      end
      S_MPC: begin
        ux = LIM;
        uy = pacc_r;
      end
      S_DV: begin
        ux = UW'(rem_t);
        uy = UW'(dd_r);
      end
      S_RA, S_RB: begin
        ux = UW'(mod_r);
        uy = UW'(rem_r);
      end
      S_DISP: begin
        ux = UW'(a_r);
        uy = UW'(b_r);
        if (act_r == ACT_ADD) begin
          uop = OP_MADD;
        end else if (act_r == ACT_SUB) begin
          uop = OP_MSUB;
        end else if (act_r == ACT_NEG) begin
          uop = OP_MSUB;
          ux  = '0;
          uy  = UW'(a_r);
        end
      end
      S_ML: begin
        uop = OP_MADD;
        ux  = UW'(acc_r);
        uy  = mph_r ? UW'(mx_r) : UW'(acc_r);
      end
      S_IV2: begin
        ux = UW'(dn_r[MW-1:0]);
        uy = UW'(mod_r);
      end
      S_IV3: begin
        uop = OP_MSUB;
        ux  = UW'(t0_r);
        uy  = UW'(acc_r);
      end
      default: begin
        uop = OP_SUB;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (start) state_nxt = modok_r ? S_CHK : S_MI;
      S_MI:   state_nxt = (prime < 16'd2 || expo == 6'd0) ? S_CHK : S_MP0;
      S_MP0:  state_nxt = (i_r == expo) ? S_CHK : S_MP;
      S_MP:   if (pcnt_r == 4'd0) state_nxt = S_MPC;
      S_MPC:  state_nxt = uge ? S_MP0 : S_CHK;
      S_CHK:  state_nxt = moderr_r ? S_OUT : S_DV;
      S_DV:   if (cnt_r == CW'(1)) state_nxt = ret_r;
      S_RA:   state_nxt = S_DV;
      S_RB:   state_nxt = S_DISP;
      S_DISP: begin
        case (act_r) inside
          ACT_MUL:          state_nxt = S_ML;
          ACT_DIV, ACT_INV: state_nxt = S_SP0;
          ACT_POW:          state_nxt = opb_r[31] ? S_FIN : S_PW;
          default:          state_nxt = S_FIN;
        endcase
      end
      S_ML:   if (mph_r && cnt_r == CW'(1)) state_nxt = ret_r;
      S_MULD: state_nxt = S_FIN;
      S_SP0:  state_nxt = (su_r == '0) ? sret_r : S_SP1;
      S_SP1:  state_nxt = (sv_r == expo) ? sret_r : S_DV;
      S_SP2:  state_nxt = (rem_r == '0) ? S_SP1 : sret_r;
      S_DVA:  state_nxt = S_SP0;
      S_DVB:  state_nxt = (b_r == '0 || sv_r > va_r) ? S_OUT : S_IV1;
      S_DVC:  state_nxt = invok_r ? S_ML : S_OUT;
      S_DVD:  state_nxt = S_DVE;
      S_DVE:  state_nxt = (k_r == 6'd0) ? S_FIN : S_ML;
      S_IV1:  state_nxt = (r1_r == '0) ? iret_r : S_DV;
      S_IV2:  state_nxt = S_ML;
      S_IV3:  state_nxt = S_IV1;
      S_IVA:  state_nxt = (a_r == '0 || sv_r != 6'd0) ? S_OUT : S_IV1;
      S_IVB:  state_nxt = invok_r ? S_FIN : S_OUT;
      S_PW: begin
        if (e_r == 32'd0) begin
          state_nxt = S_FIN;
        end else begin
          state_nxt = e_r[0] ? S_ML : S_PW3;
        end
      end
      S_PW2:  state_nxt = S_PW3;
      S_PW3:  state_nxt = S_ML;
      S_PW4:  state_nxt = S_PW;
      S_FIN:  state_nxt = S_SP0;
      S_FIN2: state_nxt = S_OUT;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Working registers.
  always_comb begin
    ret_nxt = ret_r;   sret_nxt = sret_r;  iret_nxt = iret_r;
    modok_nxt = modok_r; moderr_nxt = moderr_r; mod_nxt = mod_r;
    i_nxt = i_r; pacc_nxt = pacc_r; pcnt_nxt = pcnt_r;
    act_nxt = act_r; opa_nxt = opa_r; opb_nxt = opb_r; e_nxt = e_r;
    a_nxt = a_r; b_nxt = b_r; r_nxt = r_r; base_nxt = base_r;
    ua_nxt = ua_r; va_nxt = va_r; k_nxt = k_r; sv_nxt = sv_r; su_nxt = su_r;
    dn_nxt = dn_r; dd_nxt = dd_r; rem_nxt = rem_r; cnt_nxt = cnt_r;
    mx_nxt = mx_r; my_nxt = my_r; acc_nxt = acc_r; mph_nxt = mph_r;
    r0_nxt = r0_r; r1_nxt = r1_r; t0_nxt = t0_r; t1_nxt = t1_r;
    invok_nxt = invok_r;
    ov_nxt = 1'b0;
    ores_nxt = ores_r; ounit_nxt = ounit_r; oval_nxt = oval_r; oerr_nxt = oerr_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          act_nxt = in_action;
          opa_nxt = in_operand_a;
          opb_nxt = in_operand_b;
        end
      end
      S_MI: begin
        mod_nxt    = MW'(1);
        i_nxt      = 6'd0;
        moderr_nxt = 1'b0;
        if (prime < 16'd2 || expo == 6'd0) begin
          moderr_nxt = 1'b1;
          modok_nxt  = 1'b1;
        end
      end
      S_MP0: begin
        pacc_nxt = '0;
        pcnt_nxt = 4'd15;
        if (i_r == expo) modok_nxt = 1'b1;
      end
      S_MP: begin
        pacc_nxt = ures;
        pcnt_nxt = pcnt_r - 4'd1;
      end
      S_MPC: begin
        if (uge) begin
          mod_nxt = pacc_r[MW-1:0];
          i_nxt   = i_r + 6'd1;
        end else begin
          moderr_nxt = 1'b1;
          modok_nxt  = 1'b1;
        end
      end
      S_CHK: begin
        if (moderr_r) begin
          ores_nxt = '0; ounit_nxt = '0; oval_nxt = '0; oerr_nxt = ERR_MOD;
        end else begin
          dn_nxt  = NW'(mag32(opa_r));
          dd_nxt  = mod_r;
          rem_nxt = '0;
          cnt_nxt = CW'(NW);
          ret_nxt = S_RA;
        end
      end
      S_DV: begin
        rem_nxt = uge ? ures[MW-1:0] : rem_t[MW-1:0];
        dn_nxt  = {dn_r[NW-2:0], uge};
        cnt_nxt = cnt_r - CW'(1);
      end
      S_RA: begin
        a_nxt   = (opa_r[31] && rem_r != '0) ? ures[MW-1:0] : rem_r;
        dn_nxt  = NW'(mag32(opb_r));
        dd_nxt  = mod_r;
        rem_nxt = '0;
        cnt_nxt = CW'(NW);
        ret_nxt = S_RB;
      end
      S_RB: begin
        b_nxt = (opb_r[31] && rem_r != '0) ? ures[MW-1:0] : rem_r;
      end
      S_DISP: begin
        case (act_r) inside
          ACT_ADD, ACT_SUB, ACT_NEG: r_nxt = ures[MW-1:0];
          ACT_MUL: begin
            mx_nxt = a_r; my_nxt = b_r; acc_nxt = '0; mph_nxt = 1'b0;
            cnt_nxt = CW'(MW); ret_nxt = S_MULD;
          end
          ACT_DIV: begin
            su_nxt = a_r; sret_nxt = S_DVA;
          end
          ACT_INV: begin
            su_nxt = a_r; sret_nxt = S_IVA;
          end
          ACT_POW: begin
            r_nxt = MW'(1); base_nxt = a_r; e_nxt = opb_r;
          end
          default: r_nxt = a_r;
        endcase
      end
      S_ML: begin
        if (!mph_r) begin
          acc_nxt = ures[MW-1:0];
          mph_nxt = 1'b1;
        end else begin
          if (my_r[MW-1]) acc_nxt = ures[MW-1:0];
          my_nxt  = my_r << 1;
          cnt_nxt = cnt_r - CW'(1);
          mph_nxt = 1'b0;
        end
      end
      S_MULD: r_nxt = acc_r;
      S_SP0: begin
        if (su_r == '0) begin
          sv_nxt = expo;
        end else begin
          sv_nxt = 6'd0;
        end
      end
      S_SP1: begin
        dn_nxt  = NW'(su_r);
        dd_nxt  = MW'(prime);
        rem_nxt = '0;
        cnt_nxt = CW'(NW);
        ret_nxt = S_SP2;
      end
      S_SP2: begin
        if (rem_r == '0) begin
          su_nxt = dn_r[MW-1:0];
          sv_nxt = sv_r + 6'd1;
        end
      end
      S_DVA: begin
        va_nxt = sv_r; ua_nxt = su_r;
        su_nxt = b_r; sret_nxt = S_DVB;
      end
      S_DVB: begin
        if (b_r == '0 || sv_r > va_r) begin
          ores_nxt = '0; ounit_nxt = '0; oval_nxt = '0; oerr_nxt = ERR_DIV;
        end else begin
          r0_nxt = mod_r; r1_nxt = su_r; t0_nxt = '0; t1_nxt = MW'(1);
          iret_nxt = S_DVC;
          k_nxt = va_r - sv_r;
        end
      end
      S_DVC: begin
        if (invok_r) begin
          mx_nxt = ua_r; my_nxt = t0_r; acc_nxt = '0; mph_nxt = 1'b0;
          cnt_nxt = CW'(MW); ret_nxt = S_DVD;
        end else begin
          ores_nxt = '0; ounit_nxt = '0; oval_nxt = '0; oerr_nxt = ERR_DIV;
        end
      end
      S_DVD: r_nxt = acc_r;
      S_DVE: begin
        if (k_r != 6'd0) begin
          k_nxt = k_r - 6'd1;
          mx_nxt = r_r; my_nxt = pmod; acc_nxt = '0; mph_nxt = 1'b0;
          cnt_nxt = CW'(MW); ret_nxt = S_DVD;
        end
      end
      S_IV1: begin
        if (r1_r == '0) begin
          invok_nxt = (r0_r == MW'(1));
        end else begin
          dn_nxt  = NW'(r0_r);
          dd_nxt  = r1_r;
          rem_nxt = '0;
          cnt_nxt = CW'(NW);
          ret_nxt = S_IV2;
        end
      end
      S_IV2: begin
        // The quotient never exceeds the modulus, so one subtraction reduces it.
        mx_nxt = uge ? ures[MW-1:0] : dn_r[MW-1:0];
        my_nxt = t1_r; acc_nxt = '0; mph_nxt = 1'b0;
        cnt_nxt = CW'(MW); ret_nxt = S_IV3;
        r0_nxt = r1_r; r1_nxt = rem_r;
      end
      S_IV3: begin
        t0_nxt = t1_r;
        t1_nxt = ures[MW-1:0];
      end
      S_IVA: begin
        if (a_r == '0 || sv_r != 6'd0) begin
          ores_nxt = '0; ounit_nxt = '0; oval_nxt = '0; oerr_nxt = ERR_INV;
        end else begin
          r0_nxt = mod_r; r1_nxt = a_r; t0_nxt = '0; t1_nxt = MW'(1);
          iret_nxt = S_IVB;
        end
      end
      S_IVB: begin
        if (invok_r) begin
          r_nxt = t0_r;
        end else begin
          ores_nxt = '0; ounit_nxt = '0; oval_nxt = '0; oerr_nxt = ERR_INV;
        end
      end
      S_PW: begin
        if (e_r != 32'd0 && e_r[0]) begin
          mx_nxt = r_r; my_nxt = base_r; acc_nxt = '0; mph_nxt = 1'b0;
          cnt_nxt = CW'(MW); ret_nxt = S_PW2;
        end
      end
      S_PW2: r_nxt = acc_r;
      S_PW3: begin
        mx_nxt = base_r; my_nxt = base_r; acc_nxt = '0; mph_nxt = 1'b0;
        cnt_nxt = CW'(MW); ret_nxt = S_PW4;
      end
      S_PW4: begin
        base_nxt = acc_r;
        e_nxt    = e_r >> 1;
      end
      S_FIN: begin
        su_nxt = r_r; sret_nxt = S_FIN2;
      end
      S_FIN2: begin
        ores_nxt  = 32'(r_r);
        oval_nxt  = sv_r;
        ounit_nxt = 32'(su_r);
        oerr_nxt  = ERR_NONE;
      end
      default: begin
        ov_nxt = 1'b0;
      end
    endcase

    if (state_nxt == S_OUT) ov_nxt = 1'b1;
    // A new prime or exponent forces the modulus to be rebuilt.
    if (cfg_wr) modok_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      sret_r   <= S_IDLE;
      iret_r   <= S_IDLE;
      modok_r  <= 1'b0;
      moderr_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      sret_r   <= sret_nxt;
      iret_r   <= iret_nxt;
      modok_r  <= modok_nxt;
      moderr_r <= moderr_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mod_r <= mod_nxt;   i_r <= i_nxt;     pacc_r <= pacc_nxt; pcnt_r <= pcnt_nxt;
    act_r <= act_nxt;   opa_r <= opa_nxt; opb_r <= opb_nxt;   e_r <= e_nxt;
    a_r <= a_nxt;       b_r <= b_nxt;     r_r <= r_nxt;       base_r <= base_nxt;
    ua_r <= ua_nxt;     va_r <= va_nxt;   k_r <= k_nxt;
    sv_r <= sv_nxt;     su_r <= su_nxt;
    dn_r <= dn_nxt;     dd_r <= dd_nxt;   rem_r <= rem_nxt;   cnt_r <= cnt_nxt;
    mx_r <= mx_nxt;     my_r <= my_nxt;   acc_r <= acc_nxt;   mph_r <= mph_nxt;
    r0_r <= r0_nxt;     r1_r <= r1_nxt;   t0_r <= t0_nxt;     t1_r <= t1_nxt;
    invok_r <= invok_nxt;
    ores_r <= ores_nxt; ounit_r <= ounit_nxt; oval_r <= oval_nxt; oerr_r <= oerr_nxt;
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = ov_r;
  assign out_residue    = ores_r;
  assign out_valuation  = oval_r;
  assign out_unit_part  = ounit_r;
  assign out_error_code = oerr_r;

endmodule

// ----- src/prime_power_modular_alu_core.sv -----
// ----------------------------------------------------------------------------
// prime_power_modular_alu_core
// Arithmetic modulo p^m with p-adic valuation and unit part of every result.
//
//   Channel  Handshake              Payload
//   in       start / busy           in_action, in_operand_a, in_operand_b
//   out      out_valid strobe       out_residue, out_valuation,
//                                   out_unit_part, out_error_code
//   cfg      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One item at a time; busy stays high from the transfer until the result
// strobe. The modulus is built once after reset or a configuration write,
// one factor of p at a time. Division passes and modular multiplies run bit
// by bit on the shared adder, the valuation search divides by p until a
// remainder is left, and power takes up to about 62 multiplies.
// Reset is synchronous and sets p = 2, m = 1. Results cannot be held off.
// ----------------------------------------------------------------------------
module prime_power_modular_alu_core import ppma_pkg::*; #(
  parameter int RESIDUE_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         in_action,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               out_valid,
  output logic [31:0]        out_residue,
  output logic [5:0]         out_valuation,
  output logic [31:0]        out_unit_part,
  output logic [1:0]         out_error_code,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  logic [15:0] prime_r;
  logic [5:0]  expo_r;
  logic        cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prime_r <= 16'd2;
      expo_r  <= 6'd1;
    end else if (cfg_wr) begin
      if (cfg_index == REG_PRIME) prime_r <= cfg_data;
      if (cfg_index == REG_EXP)   expo_r  <= cfg_data[5:0];
    end
  end

  ppma_seq #(.RESIDUE_WIDTH(RESIDUE_WIDTH)) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_operand_a   (in_operand_a),
    .in_operand_b   (in_operand_b),
    .prime          (prime_r),
    .expo           (expo_r),
    .cfg_wr         (cfg_wr),
    .out_valid      (out_valid),
    .out_residue    (out_residue),
    .out_valuation  (out_valuation),
    .out_unit_part  (out_unit_part),
    .out_error_code (out_error_code)
  );

endmodule
